// ===== hdl/dtpw_pkg.sv =====
// Package for the depth-tested alpha-blend pixel writer.
// Holds the shared codes, state and handshake types, and default sizes.
// No dependencies.
package dtpw_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int DEPTH_BITS_DEF = 24;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_W-1:0] FRAME_RESET = 9'd256;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_WRITTEN  = 3'd0,
    ST_OUTSIDE  = 3'd1,
    ST_REJECTED = 3'd2,
    ST_READ     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    K_PUT,
    K_READ,
    K_CLEAR,
    K_OUTSIDE
  } kind_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CALC,
    S_SWEEP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_ctrl_t;

endpackage

// ===== hdl/dtpw_if.sv =====
// Handshake channels of the pixel writer: the request item and the result item.
// Depends on nothing; field widths follow the item definitions.
interface dtpw_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [11:0] pos_x;
  logic signed [11:0] pos_y;
  logic signed [23:0] depth_in;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;

  modport source (output valid, op, pos_x, pos_y, depth_in, red, green, blue, alpha,
                  input ready);
  modport sink (input valid, op, pos_x, pos_y, depth_in, red, green, blue, alpha,
                output ready);
endinterface

interface dtpw_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (output valid, status, out_red, out_green, out_blue, out_alpha,
                  input ready);
  modport sink (input valid, status, out_red, out_green, out_blue, out_alpha,
                output ready);
endinterface

// ===== hdl/depth_tested_alpha_blend_pixel_writer.sv =====
// Top level of the depth-tested alpha-blend pixel writer.
// Depends on dtpw_pkg, dtpw_if, dtpw_front and dtpw_back.
//
// Frame buffer of MAX_WIDTH x MAX_HEIGHT RGBA pixels with a depth buffer. A put
// passes the depth test when the stored depth is empty or not greater than the
// new one, then blends its color over the pixel; a read returns a pixel and a
// clear fills the whole store. Items are queued two deep in front of a
// sequencer that owns the two single-write-port memories and handles one item
// at a time: a put or read passes through address, memory read, blend and
// write-back and result hand-off, an item outside the frame goes straight to
// the result hand-off, and a clear writes both memories, one entry per cycle.
// After reset all MAX_WIDTH*MAX_HEIGHT depth entries are swept
// (65536 at the default size) while no item is taken; register writes are
// taken throughout. The result register lets the next item proceed while a
// result waits.
module depth_tested_alpha_blend_pixel_writer #(
  parameter int MAX_WIDTH  = dtpw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtpw_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = dtpw_pkg::DEPTH_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [dtpw_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [dtpw_pkg::CFG_W-1:0]     wr_data,
  dtpw_in_if.sink                        pix_in,
  dtpw_out_if.source                     pix_out
);
  import dtpw_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

  q_head_t                      head;
  back_ctrl_t                   ctrl;
  logic [AW-1:0]                head_addr;
  logic signed [DEPTH_BITS-1:0] head_z;
  logic [31:0]                  head_color;

  dtpw_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .pix_in     (pix_in),
    .ctrl       (ctrl),
    .head       (head),
    .head_addr  (head_addr),
    .head_z     (head_z),
    .head_color (head_color)
  );

  dtpw_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_addr  (head_addr),
    .head_z     (head_z),
    .head_color (head_color),
    .ctrl       (ctrl),
    .pix_out    (pix_out)
  );

endmodule

// ===== hdl/dtpw_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module dtpw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/dtpw_front.sv =====
// Front end: frame size registers, request classification and the item queue.
// Depends on dtpw_pkg and dtpw_in_if.
module dtpw_front #(
  parameter int MAX_WIDTH  = dtpw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtpw_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = dtpw_pkg::DEPTH_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            wr_en,
  input  logic [dtpw_pkg::CFG_IDX_W-1:0]                  wr_index,
  input  logic [dtpw_pkg::CFG_W-1:0]                      wr_data,
  dtpw_in_if.sink                                         pix_in,
  input  dtpw_pkg::back_ctrl_t                            ctrl,
  output dtpw_pkg::q_head_t                               head,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]         head_addr,
  output logic signed [DEPTH_BITS-1:0]                    head_z,
  output logic [31:0]                                     head_color
);
  import dtpw_pkg::*;

  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(PIXELS);

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  kind_t                  q_kind  [QUEUE_DEPTH];
  logic [AW-1:0]          q_addr  [QUEUE_DEPTH];
  logic [DEPTH_BITS-1:0]  q_z     [QUEUE_DEPTH];
  logic [31:0]            q_color [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr;
  logic [QPTR_W-1:0]      rd_ptr;
  logic [QCNT_W-1:0]      count;

  logic                   push;
  logic                   x_ok;
  logic                   y_ok;
  kind_t                  kind_in;
  logic [AW-1:0]          addr_in;
  logic signed [31:0]     z_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_RESET;
      frame_height <= FRAME_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_FRAME_WIDTH:  frame_width  <= wr_data;
        REG_FRAME_HEIGHT: frame_height <= wr_data;
        default: ;
      endcase
    end
  end

  assign x_ok = !pix_in.pos_x[11]
             && ({2'b00, pix_in.pos_x[10:0]} < {4'b0000, frame_width})
             && (32'(pix_in.pos_x[10:0]) < 32'(MAX_WIDTH));
  assign y_ok = !pix_in.pos_y[11]
             && ({2'b00, pix_in.pos_y[10:0]} < {4'b0000, frame_height})
             && (32'(pix_in.pos_y[10:0]) < 32'(MAX_HEIGHT));

  assign addr_in = AW'(32'(pix_in.pos_y[10:0]) * 32'(MAX_WIDTH) + 32'(pix_in.pos_x[10:0]));
  assign z_wide  = 32'(pix_in.depth_in);

  always_comb begin
    case (pix_in.op)
      OP_CLEAR: kind_in = K_CLEAR;
      OP_PUT:   kind_in = (x_ok && y_ok) ? K_PUT : K_OUTSIDE;
      default:  kind_in = (x_ok && y_ok) ? K_READ : K_OUTSIDE;
    endcase
  end

  assign pix_in.ready = (count != QCNT_W'(QUEUE_DEPTH)) && !ctrl.init_busy;
  assign push         = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_kind[wr_ptr]  <= kind_in;
      q_addr[wr_ptr]  <= addr_in;
      q_z[wr_ptr]     <= z_wide[DEPTH_BITS-1:0];
      q_color[wr_ptr] <= {pix_in.alpha, pix_in.blue, pix_in.green, pix_in.red};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (ctrl.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !ctrl.pop) begin
        count <= count + 1'b1;
      end else if (!push && ctrl.pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head.valid = (count != '0);
  assign head.kind  = q_kind[rd_ptr];
  assign head_addr  = q_addr[rd_ptr];
  assign head_z     = q_z[rd_ptr];
  assign head_color = q_color[rd_ptr];

endmodule

// ===== hdl/dtpw_back.sv =====
// Back end: sequencer over the color and depth memories, blend datapath and
// the result register. Depends on dtpw_pkg, dtpw_out_if and dtpw_ram.
module dtpw_back #(
  parameter int MAX_WIDTH  = dtpw_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dtpw_pkg::MAX_HEIGHT_DEF,
  parameter int DEPTH_BITS = dtpw_pkg::DEPTH_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  dtpw_pkg::q_head_t                       head,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] head_addr,
  input  logic signed [DEPTH_BITS-1:0]            head_z,
  input  logic [31:0]                             head_color,
  output dtpw_pkg::back_ctrl_t                    ctrl,
  dtpw_out_if.source                              pix_out
);
  import dtpw_pkg::*;

  localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(PIXELS);

  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'(v[15:8]) + 17'd1;
    return s[15:8];
  endfunction

  state_t state;
  state_t state_next;

  kind_t                  cur_kind;
  logic [AW-1:0]          cur_addr;
  logic signed [DEPTH_BITS-1:0] cur_z;
  logic [31:0]            cur_color;
  logic [AW-1:0]          sweep_addr;
  logic                   sweep_last;

  logic [15:0]            sum_r;
  logic [15:0]            sum_g;
  logic [15:0]            sum_b;
  logic [15:0]            sum_a;
  logic                   pass;
  logic [31:0]            dst;

  logic [31:0]            color_q;
  logic [DEPTH_BITS:0]    dword_q;
  logic                   rd_en;
  logic                   color_we;
  logic                   depth_we;
  logic [AW-1:0]          wr_addr;
  logic [31:0]            color_wdata;
  logic [DEPTH_BITS:0]    depth_wdata;

  logic [7:0]             inv_a;
  logic [7:0]             new_r;
  logic [7:0]             new_g;
  logic [7:0]             new_b;
  logic [8:0]             alpha_sum;
  logic [7:0]             new_a;
  logic [31:0]            new_color;

  logic                   res_load;
  status_t                res_status_v;
  logic [31:0]            res_color_v;
  status_t                res_status;
  logic [31:0]            res_color;

  logic                   out_free;
  logic                   out_load;
  logic                   out_valid;
  status_t                out_status;
  logic [31:0]            out_color;

  dtpw_ram #(.WIDTH(32), .DEPTH(PIXELS)) u_color_ram (
    .clk     (clk),
    .wr_en   (color_we),
    .wr_addr (wr_addr),
    .wr_data (color_wdata),
    .rd_en   (rd_en),
    .rd_addr (head_addr),
    .rd_data (color_q)
  );

  dtpw_ram #(.WIDTH(DEPTH_BITS + 1), .DEPTH(PIXELS)) u_depth_ram (
    .clk     (clk),
    .wr_en   (depth_we),
    .wr_addr (wr_addr),
    .wr_data (depth_wdata),
    .rd_en   (rd_en),
    .rd_addr (head_addr),
    .rd_data (dword_q)
  );

  assign sweep_last = (sweep_addr == AW'(PIXELS - 1));
  assign out_free   = !out_valid || pix_out.ready;

  // Blend arithmetic on the registered sums.
  assign inv_a     = 8'd255 - cur_color[31:24];
  assign new_r     = div255(sum_r);
  assign new_g     = div255(sum_g);
  assign new_b     = div255(sum_b);
  assign alpha_sum = {1'b0, cur_color[31:24]} + {1'b0, div255(sum_a)};
  assign new_a     = alpha_sum[8] ? 8'hff : alpha_sum[7:0];
  assign new_color = {new_a, new_b, new_g, new_r};

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          case (head.kind)
            K_CLEAR:   state_next = S_SWEEP;
            K_OUTSIDE: state_next = S_RESP;
            default:   state_next = S_READ;
          endcase
        end
      end
      S_READ:  state_next = S_CALC;
      S_CALC:  state_next = S_RESP;
      S_SWEEP: begin
        if (sweep_last) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.pop       = 1'b0;
    ctrl.init_busy = (state == S_INIT);
    rd_en          = 1'b0;
    color_we       = 1'b0;
    depth_we       = 1'b0;
    res_load       = 1'b0;
    res_status_v   = ST_READ;
    res_color_v    = dst;
    out_load       = 1'b0;
    case (state)
      S_INIT: begin
        depth_we = 1'b1;
      end
      S_IDLE: begin
        if (head.valid) begin
          ctrl.pop = 1'b1;
          if (head.kind == K_OUTSIDE) begin
            res_load     = 1'b1;
            res_status_v = ST_OUTSIDE;
            res_color_v  = '0;
          end else if (head.kind inside {K_PUT, K_READ}) begin
            rd_en = 1'b1;
          end
        end
      end
      S_CALC: begin
        res_load = 1'b1;
        if (cur_kind == K_PUT) begin
          if (pass) begin
            color_we     = 1'b1;
            depth_we     = 1'b1;
            res_status_v = ST_WRITTEN;
            res_color_v  = new_color;
          end else begin
            res_status_v = ST_REJECTED;
          end
        end
      end
      S_SWEEP: begin
        color_we = 1'b1;
        depth_we = 1'b1;
        if (sweep_last) begin
          res_load     = 1'b1;
          res_status_v = ST_CLEARED;
          res_color_v  = cur_color;
        end
      end
      S_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  assign wr_addr     = (state == S_CALC) ? cur_addr : sweep_addr;
  assign color_wdata = (state == S_CALC) ? new_color : cur_color;
  assign depth_wdata = (state == S_CALC) ? {1'b1, cur_z} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      sweep_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT || state == S_SWEEP) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pix_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      cur_kind  <= head.kind;
      cur_addr  <= head_addr;
      cur_z     <= head_z;
      cur_color <= head_color;
    end
    if (state == S_READ) begin
      sum_r <= 16'(cur_color[31:24]) * 16'(cur_color[7:0])
             + 16'(inv_a) * 16'(color_q[7:0]);
      sum_g <= 16'(cur_color[31:24]) * 16'(cur_color[15:8])
             + 16'(inv_a) * 16'(color_q[15:8]);
      sum_b <= 16'(cur_color[31:24]) * 16'(cur_color[23:16])
             + 16'(inv_a) * 16'(color_q[23:16]);
      sum_a <= 16'(color_q[31:24]) * 16'(inv_a);
      pass  <= !dword_q[DEPTH_BITS]
            || !($signed(dword_q[DEPTH_BITS-1:0]) > cur_z);
      dst   <= color_q;
    end
    if (res_load) begin
      res_status <= res_status_v;
      res_color  <= res_color_v;
    end
    if (out_load) begin
      out_status <= res_status;
      out_color  <= res_color;
    end
  end

  assign pix_out.valid     = out_valid;
  assign pix_out.status    = out_status;
  assign pix_out.out_red   = out_color[7:0];
  assign pix_out.out_green = out_color[15:8];
  assign pix_out.out_blue  = out_color[23:16];
  assign pix_out.out_alpha = out_color[31:24];

endmodule

// ===== hdl/dtpw_checker.sv =====
// Port-level checks for the pixel writer and the bind that attaches them.
// Depends on dtpw_pkg and depth_tested_alpha_blend_pixel_writer.
module dtpw_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic [7:0] out_alpha
);
  import dtpw_pkg::*;

  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  // No item is taken in the cycle after reset, while the depth memory is swept.
  a_init_stall: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("item taken right after reset");

  // Every result belongs to an item already taken.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result without an outstanding item");

  // A pixel outside the frame reports a zero color.
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OUTSIDE |->
      out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0 && out_alpha == 8'd0)
    else $error("nonzero color on an outside result");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_red)
      && $stable(out_green) && $stable(out_blue) && $stable(out_alpha))
    else $error("stalled result changed");

endmodule

bind depth_tested_alpha_blend_pixel_writer dtpw_checker u_dtpw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .status    (pix_out.status),
  .out_red   (pix_out.out_red),
  .out_green (pix_out.out_green),
  .out_blue  (pix_out.out_blue),
  .out_alpha (pix_out.out_alpha)
);

// ===== tb/sv/tb_depth_tested_alpha_blend_pixel_writer.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the depth-tested alpha-blend pixel writer.
// Drives puts, reads and clears with random idling on both channels and checks every result.
// Depends on dtpw_pkg, dtpw_if and depth_tested_alpha_blend_pixel_writer.
module tb_depth_tested_alpha_blend_pixel_writer;
  import dtpw_pkg::*;

  localparam int PIXEL_COUNT = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int DIRECTED_COUNT = 23;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 166;
  localparam int RANDOM_CLEARS = 3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT = 10;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic signed [23:0] depth;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } pixel_req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_res_t;

  typedef struct packed {
    pixel_req_t req;
    logic       typed;
    pixel_res_t res;
  } directed_row_t;

  localparam pixel_res_t OUTSIDE_RES = '{ST_OUTSIDE, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam pixel_res_t NONE = '{ST_WRITTEN, 8'h00, 8'h00, 8'h00, 8'h00};

  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{'{OP_PUT, -12'sd1, 12'sd0, 24'sd0, 8'h01, 8'h02, 8'h03, 8'h04}, 1'b1, OUTSIDE_RES},
    '{'{OP_READ, 12'sd0, 12'sh800, 24'sd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, OUTSIDE_RES},
    '{'{OP_PUT, 12'sd2047, 12'sd5, 24'sd0, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1, OUTSIDE_RES},
    '{'{OP_READ, 12'sd256, 12'sd0, 24'sd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, OUTSIDE_RES},
    '{'{OP_SPARE, 12'sd0, 12'sd256, 24'sd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, OUTSIDE_RES},
    '{'{OP_CLEAR, 12'sd100, -12'sd7, 24'sd123, 8'h12, 8'h34, 8'h56, 8'h78}, 1'b1,
      '{ST_CLEARED, 8'h12, 8'h34, 8'h56, 8'h78}},
    '{'{OP_READ, 12'sd0, 12'sd0, 24'sd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{ST_READ, 8'h12, 8'h34, 8'h56, 8'h78}},
    '{'{OP_SPARE, 12'sd255, 12'sd255, 24'sd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{ST_READ, 8'h12, 8'h34, 8'h56, 8'h78}},
    '{'{OP_PUT, 12'sd255, 12'sd255, 24'sd0, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1,
      '{ST_WRITTEN, 8'hff, 8'hff, 8'hff, 8'hff}},
    '{'{OP_PUT, 12'sd255, 12'sd255, 24'sd1, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NONE},
    '{'{OP_PUT, 12'sd255, 12'sd255, 24'sd0, 8'h10, 8'h20, 8'h30, 8'hff}, 1'b0, NONE},
    '{'{OP_PUT, 12'sd255, 12'sd255, 24'sd1, 8'h00, 8'h00, 8'h00, 8'h80}, 1'b0, NONE},
    '{'{OP_PUT, 12'sd0, 12'sd0, 24'sh800000, 8'h00, 8'h00, 8'h00, 8'hff}, 1'b0, NONE},
    '{'{OP_PUT, 12'sd0, 12'sd0, 24'sh7fffff, 8'hc8, 8'h64, 8'h32, 8'h4d}, 1'b0, NONE},
    '{'{OP_PUT, 12'sd0, 12'sd0, 24'sh800000, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b0, NONE},
    '{'{OP_PUT, 12'sd0, 12'sd0, 24'sh7fffff, 8'h01, 8'h02, 8'h03, 8'hff}, 1'b0, NONE},
    '{'{OP_READ, 12'sd0, 12'sd0, 24'sd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NONE},
    '{'{OP_PUT, 12'sd10, 12'sd20, 24'sh400000, 8'h55, 8'haa, 8'h55, 8'h01}, 1'b0, NONE},
    '{'{OP_CLEAR, 12'sd0, 12'sd0, 24'sd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
      '{ST_CLEARED, 8'h00, 8'h00, 8'h00, 8'h00}},
    '{'{OP_PUT, 12'sd0, 12'sd0, 24'sh800000, 8'hff, 8'hff, 8'hff, 8'h00}, 1'b0, NONE},
    '{'{OP_PUT, 12'sd128, 12'sd64, 24'sh7f0000, 8'haa, 8'h55, 8'haa, 8'hff}, 1'b0, NONE},
    '{'{OP_READ, 12'sd128, 12'sd64, 24'sd0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, NONE},
    '{'{OP_PUT, 12'sh800, 12'sd2047, 24'sd9, 8'h0f, 8'hf0, 8'h3c, 8'hc3}, 1'b1, OUTSIDE_RES}
  };

  localparam logic [8:0] PHASE_WIDTH [RANDOM_PHASES] =
    '{9'd256, 9'd1, 9'd511, 9'd0, 9'd12, 9'd16, 9'd257, 9'd40};
  localparam logic [8:0] PHASE_HEIGHT [RANDOM_PHASES] =
    '{9'd256, 9'd1, 9'd300, 9'd12, 9'd0, 9'd16, 9'd2, 9'd5};

  logic clk;
  logic rst;
  logic wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0] wr_data;

  dtpw_in_if pixel_req_ch ();
  dtpw_out_if pixel_res_ch ();

  depth_tested_alpha_blend_pixel_writer dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pix_in   (pixel_req_ch),
    .pix_out  (pixel_res_ch)
  );

  logic [31:0]        frame_color [PIXEL_COUNT];
  logic signed [23:0] frame_depth [PIXEL_COUNT];
  logic [PIXEL_COUNT-1:0] depth_filled;
  logic [8:0] frame_width_cfg;
  logic [8:0] frame_height_cfg;

  pixel_res_t pending_pixels [$];
  int mismatches;
  int results_seen;
  int items_sent;
  int cycle_count;
  logic send_steady;
  int n_written, n_rejected, n_outside, n_read, n_cleared;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] mix_channel(input int unsigned a, input int unsigned src,
                                             input int unsigned dst);
    return 8'((a * src + (255 - a) * dst) / 255);
  endfunction

  function automatic pixel_res_t apply_request(input pixel_req_t req);
    int w, h, x, y, idx;
    int unsigned a, dst_a;
    logic [31:0] dst;
    pixel_res_t res;
    w = (frame_width_cfg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(frame_width_cfg);
    h = (frame_height_cfg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(frame_height_cfg);
    res = OUTSIDE_RES;
    if (req.op == OP_CLEAR) begin
      for (int i = 0; i < PIXEL_COUNT; i++) begin
        frame_color[i] = {req.alpha, req.blue, req.green, req.red};
      end
      depth_filled = '0;
      res = '{ST_CLEARED, req.red, req.green, req.blue, req.alpha};
      return res;
    end
    x = int'(req.pos_x);
    y = int'(req.pos_y);
    if (x < 0 || y < 0 || x >= w || y >= h) begin
      return res;
    end
    idx = y * MAX_WIDTH_DEF + x;
    dst = frame_color[idx];
    res = '{ST_READ, dst[7:0], dst[15:8], dst[23:16], dst[31:24]};
    if (req.op != OP_PUT) begin
      return res;
    end
    if (depth_filled[idx] && frame_depth[idx] > $signed(req.depth)) begin
      res.status = ST_REJECTED;
      return res;
    end
    frame_depth[idx] = req.depth;
    depth_filled[idx] = 1'b1;
    a = 32'(req.alpha);
    dst_a = 32'(dst[31:24]);
    res.status = ST_WRITTEN;
    res.red = mix_channel(a, 32'(req.red), 32'(dst[7:0]));
    res.green = mix_channel(a, 32'(req.green), 32'(dst[15:8]));
    res.blue = mix_channel(a, 32'(req.blue), 32'(dst[23:16]));
    res.alpha = 8'(a + (dst_a * (255 - a)) / 255);
    frame_color[idx] = {res.alpha, res.blue, res.green, res.red};
    return res;
  endfunction

  function automatic int pick_coord(input int limit, input int mode);
    int v;
    case (mode)
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0: v = -1;
          1: v = 0;
          2: v = limit - 1;
          3: v = limit;
          4: v = 2047;
          default: v = -2048;
        endcase
      end
      2: v = (limit > 0) ? int'($urandom_range(0, limit - 1)) : int'($urandom);
      default: v = (limit > 0) ? int'($urandom_range(0, ((limit < 6) ? limit : 6) - 1))
                               : int'($urandom);
    endcase
    return v;
  endfunction

  function automatic pixel_req_t random_request(input int w, input int h);
    pixel_req_t req;
    int pick, mode, x, y, dv;
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      req.op = OP_PUT;
    end else if (pick < 90) begin
      req.op = OP_READ;
    end else begin
      req.op = OP_SPARE;
    end
    pick = $urandom_range(0, 9);
    mode = (pick == 0) ? 0 : (pick == 1) ? 1 : (pick < 4) ? 2 : 3;
    x = pick_coord(w, mode);
    y = pick_coord(h, mode);
    req.pos_x = x[11:0];
    req.pos_y = y[11:0];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: dv = $urandom;
      4, 5, 6: dv = (int'($urandom_range(0, 4)) - 2) * 65536;
      7: dv = 32'h007f_ffff;
      8: dv = 32'h0080_0000;
      default: dv = $urandom_range(0, 15);
    endcase
    req.depth = dv[23:0];
    req.red = 8'($urandom);
    req.green = 8'($urandom);
    req.blue = 8'($urandom);
    case ($urandom_range(0, 3))
      0: req.alpha = 8'h00;
      1: req.alpha = 8'hff;
      default: req.alpha = 8'($urandom);
    endcase
    return req;
  endfunction

  task automatic send_pixel(input pixel_req_t req, input logic typed,
                            input pixel_res_t typed_res);
    int gap;
    pixel_res_t predicted;
    if (items_sent % 48 == 0) begin
      send_steady = ($urandom_range(0, 3) == 0);
    end
    gap = send_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      pixel_req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_req_ch.valid <= 1'b1;
    pixel_req_ch.op <= req.op;
    pixel_req_ch.pos_x <= req.pos_x;
    pixel_req_ch.pos_y <= req.pos_y;
    pixel_req_ch.depth_in <= req.depth;
    pixel_req_ch.red <= req.red;
    pixel_req_ch.green <= req.green;
    pixel_req_ch.blue <= req.blue;
    pixel_req_ch.alpha <= req.alpha;
    do @(posedge clk); while (pixel_req_ch.ready !== 1'b1);
    predicted = apply_request(req);
    pending_pixels.push_back(typed ? typed_res : predicted);
    items_sent++;
    case (predicted.status)
      ST_WRITTEN: n_written++;
      ST_REJECTED: n_rejected++;
      ST_OUTSIDE: n_outside++;
      ST_READ: n_read++;
      default: n_cleared++;
    endcase
  endtask

  task automatic wait_for_drain();
    pixel_req_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_size(input logic [8:0] w, input logic [8:0] h);
    wr_en <= 1'b1;
    wr_index <= REG_FRAME_WIDTH;
    wr_data <= w;
    @(posedge clk);
    wr_index <= REG_FRAME_HEIGHT;
    wr_data <= h;
    @(posedge clk);
    wr_en <= 1'b0;
    frame_width_cfg = w;
    frame_height_cfg = h;
  endtask

  initial begin
    pixel_req_t req;
    logic [8:0] w, h;
    int clears_left;
    rst <= 1'b1;
    wr_en <= 1'b0;
    wr_index <= REG_FRAME_WIDTH;
    wr_data <= '0;
    pixel_req_ch.valid <= 1'b0;
    pixel_req_ch.op <= OP_PUT;
    pixel_req_ch.pos_x <= '0;
    pixel_req_ch.pos_y <= '0;
    pixel_req_ch.depth_in <= '0;
    pixel_req_ch.red <= '0;
    pixel_req_ch.green <= '0;
    pixel_req_ch.blue <= '0;
    pixel_req_ch.alpha <= '0;
    frame_width_cfg = FRAME_RESET;
    frame_height_cfg = FRAME_RESET;
    depth_filled = '0;
    mismatches = 0;
    items_sent = 0;
    send_steady = 1'b0;
    clears_left = RANDOM_CLEARS;
    {n_written, n_rejected, n_outside, n_read, n_cleared} = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_pixel(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_drain();
      w = PHASE_WIDTH[p];
      h = PHASE_HEIGHT[p];
      if (p == RANDOM_PHASES - 1) begin
        w = 9'($urandom_range(1, 256));
        h = 9'($urandom_range(1, 256));
      end
      write_frame_size(w, h);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        req = random_request((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(w),
                             (h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(h));
        if (clears_left > 0 && $urandom_range(0, 199) == 0) begin
          req.op = OP_CLEAR;
          clears_left--;
        end
        send_pixel(req, 1'b0, NONE);
      end
    end

    wait_for_drain();
    $display("Sent %0d items over %0d frame sizes: %0d written, %0d depth-rejected,",
             items_sent, RANDOM_PHASES + 1, n_written, n_rejected);
    $display("%0d outside the frame, %0d reads, %0d clears; %0d results compared.",
             n_outside, n_read, n_cleared, results_seen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int stall;
    logic calm;
    pixel_res_t got, want;
    pixel_res_ch.ready <= 1'b0;
    results_seen = 0;
    calm = 1'b0;
    forever begin
      if (results_seen % 40 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        pixel_res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pixel_res_ch.ready <= 1'b1;
      do @(posedge clk); while (pixel_res_ch.valid !== 1'b1);
      results_seen++;
      got = '{status_t'(pixel_res_ch.status), pixel_res_ch.out_red, pixel_res_ch.out_green,
              pixel_res_ch.out_blue, pixel_res_ch.out_alpha};
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("result %0d arrived with nothing pending: status %0d rgba %h %h %h %h",
                   results_seen, got.status, got.red, got.green, got.blue, got.alpha);
        end
      end else begin
        want = pending_pixels.pop_front();
        if (got.status !== want.status || got.red !== want.red || got.green !== want.green ||
            got.blue !== want.blue || got.alpha !== want.alpha) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("result %0d: expected status %0d rgba %h %h %h %h, got status %0d %s",
                     results_seen, want.status, want.red, want.green, want.blue, want.alpha,
                     got.status, $sformatf("rgba %h %h %h %h", got.red, got.green, got.blue,
                                           got.alpha));
          end
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results still pending.", cycle_count,
             pending_pixels.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
